>>> rtl/btd_pkg.sv
`default_nettype none

package btd_pkg;

  localparam int BLOCK_BYTES   = 512;
  localparam int TRAILER_BYTES = 2;

  localparam int CNT_W = 10;
  localparam int SEQ_W = 8;

  localparam logic [7:0] BYTE_SOH = 8'h01;
  localparam logic [7:0] BYTE_EOT = 8'h04;
  localparam logic [8:0] CSEQ_SUM = 9'd255;

  localparam logic [2:0] PH_STOPPED  = 3'd0;
  localparam logic [2:0] PH_BOUNDARY = 3'd1;
  localparam logic [2:0] PH_SEQ      = 3'd2;
  localparam logic [2:0] PH_CSEQ     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD  = 3'd4;
  localparam logic [2:0] PH_TRAILER  = 3'd5;

  localparam logic [2:0] KIND_NONE      = 3'd0;
  localparam logic [2:0] KIND_PAYLOAD   = 3'd1;
  localparam logic [2:0] KIND_BLOCK_ACK = 3'd2;
  localparam logic [2:0] KIND_END_ACK   = 3'd3;
  localparam logic [2:0] KIND_ERROR     = 3'd4;

  localparam logic [CNT_W:0] BLOCK_LAST   = (CNT_W+1)'(BLOCK_BYTES);
  localparam logic [CNT_W:0] TRAILER_LAST = (CNT_W+1)'(TRAILER_BYTES);
  localparam logic [SEQ_W-1:0] SEQ_FIRST  = SEQ_W'(1);

  typedef struct packed {
    logic [2:0]       phase;
    logic [SEQ_W-1:0] seq;
    logic [CNT_W-1:0] count;
  } btd_state_t;

endpackage

`default_nettype wire

>>> rtl/btd_step.sv
`default_nettype none

module btd_step
  import btd_pkg::*;
(
  input  wire btd_state_t cur,
  input  wire             func,
  input  wire [7:0]       rx_byte,
  output btd_state_t      nxt,
  output logic [2:0]      kind,
  output logic [7:0]      ob
);

  logic [CNT_W:0] cnt_inc;
  logic [8:0]     cseq_sum;

  assign cnt_inc  = {1'b0, cur.count} + (CNT_W+1)'(1);
  assign cseq_sum = {1'b0, rx_byte} + {1'b0, cur.seq};

  always_comb begin
    nxt  = cur;
    kind = KIND_NONE;
    ob   = 8'd0;
    if (func) begin
      nxt.phase = PH_BOUNDARY;
      nxt.seq   = SEQ_FIRST;
      nxt.count = '0;
    end else begin
      unique case (cur.phase)
        PH_BOUNDARY: begin
          if (rx_byte == BYTE_EOT) begin
            kind      = KIND_END_ACK;
            nxt.phase = PH_STOPPED;
          end else if (rx_byte == BYTE_SOH) begin
            nxt.phase = PH_SEQ;
          end else begin
            kind      = KIND_ERROR;
            nxt.phase = PH_STOPPED;
          end
        end
        PH_SEQ: begin
          if (rx_byte == cur.seq) begin
            nxt.phase = PH_CSEQ;
          end else begin
            kind      = KIND_ERROR;
            nxt.phase = PH_STOPPED;
          end
        end
        PH_CSEQ: begin
          if (cseq_sum == CSEQ_SUM) begin
            nxt.phase = PH_PAYLOAD;
            nxt.count = '0;
          end else begin
            kind      = KIND_ERROR;
            nxt.phase = PH_STOPPED;
          end
        end
        PH_PAYLOAD: begin
          kind = KIND_PAYLOAD;
          ob   = rx_byte;
          if (cnt_inc >= BLOCK_LAST) begin
            nxt.count = '0;
            if (TRAILER_BYTES == 0) begin
              // no trailer: ack rides on the last payload byte
              kind      = KIND_BLOCK_ACK;
              nxt.seq   = cur.seq + SEQ_W'(1);
              nxt.phase = PH_BOUNDARY;
            end else begin
              nxt.phase = PH_TRAILER;
            end
          end else begin
            nxt.count = cnt_inc[CNT_W-1:0];
          end
        end
        PH_TRAILER: begin
          if (cnt_inc >= TRAILER_LAST) begin
            kind      = KIND_BLOCK_ACK;
            nxt.seq   = cur.seq + SEQ_W'(1);
            nxt.count = '0;
            nxt.phase = PH_BOUNDARY;
          end else begin
            nxt.count = cnt_inc[CNT_W-1:0];
          end
        end
        default: begin
          // stopped: drop the byte
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/block_transfer_deframer.sv
`default_nettype none

// Block transfer deframer: takes one byte-stream transfer per cycle, unless
// stalled, and gives one result per input transfer.
// Input channel: in_valid/in_ready with in_func (1 = start a new transfer,
// 0 = received byte) and in_rx_byte.
// Result channel: out_valid/out_ready with out_byte (payload byte), out_kind
// (none, payload, block ack, end ack, error) and out_block_number (the
// expected block number after this byte).
// Each input transfer is held in the input register, then moves to the
// result register, where the framing state advances as the result is
// loaded; a stalled result register keeps it in the input register.
// Throughput: one transfer per cycle unless stalled; the framing state update
// is a single compare and count step, so consecutive bytes need no gap.
// Reset (rst_n low, synchronous) empties both registers and puts the
// receiver in the stopped phase with block number 1; bytes are ignored until
// a start transfer.
// When the receiver stalls, the result register holds, the input register
// fills, and in_ready drops until out_ready returns. Nothing is lost.

module block_transfer_deframer
  import btd_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire        in_func,
  input  wire [7:0]  in_rx_byte,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [7:0] out_byte,
  output logic [2:0] out_kind,
  output logic [7:0] out_block_number
);

  logic       in_valid_r;
  logic       func_r;
  logic [7:0] rx_byte_r;

  btd_state_t st_r;
  btd_state_t st_nxt;

  logic       out_valid_r;
  logic [7:0] ob_r;
  logic [2:0] kind_r;
  logic [7:0] bn_r;

  logic [7:0] ob_nxt;
  logic [2:0] kind_nxt;
  logic       adv;

  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  btd_step u_step (
    .cur     (st_r),
    .func    (func_r),
    .rx_byte (rx_byte_r),
    .nxt     (st_nxt),
    .kind    (kind_nxt),
    .ob      (ob_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      func_r    <= in_func;
      rx_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase <= PH_STOPPED;
      st_r.seq   <= SEQ_FIRST;
      st_r.count <= '0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ob_r   <= ob_nxt;
      kind_r <= kind_nxt;
      bn_r   <= st_nxt.seq;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = ob_r;
  assign out_kind         = kind_r;
  assign out_block_number = bn_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, st_r.count} < BLOCK_LAST))
    else $error("byte count past block size");

  a_ack_boundary: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_BLOCK_ACK) |-> (st_r.phase == PH_BOUNDARY))
    else $error("block ack without return to boundary");

  a_stop_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (kind_r == KIND_END_ACK || kind_r == KIND_ERROR))
      |-> (st_r.phase == PH_STOPPED))
    else $error("end or error without stop");

  a_bn_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (bn_r == st_r.seq))
    else $error("block number out of step with state");

endmodule

`default_nettype wire

>>> test/tb_block_transfer_deframer.sv
`timescale 1ns / 1ps

module tb_block_transfer_deframer
  import btd_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_ITEMS   = 700;

  localparam int FAULT_NONE    = 0;
  localparam int FAULT_SEQ     = 1;
  localparam int FAULT_CSEQ    = 2;
  localparam int FAULT_RESTART = 3;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] kind;
    logic [7:0] blk;
  } frame_res_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_func    = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_ready  = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic [2:0] out_kind;
  logic [7:0] out_block_number;

  // receiver state as predicted by the testbench
  logic [2:0] rx_phase  = PH_STOPPED;
  logic [7:0] want_seq  = SEQ_FIRST;
  logic [9:0] pay_count = '0;

  frame_res_t pending_results[$];
  frame_res_t got_r;
  frame_res_t want_r;
  int         fail_count = 0;
  int         live_items = 0;
  int         idle_run   = 0;
  int         stall_left = 0;
  bit         idle_en    = 1'b1;

  block_transfer_deframer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_kind         (out_kind),
    .out_block_number (out_block_number)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom);
  endfunction

  // advance the predicted receiver by one accepted transfer
  function automatic void deframe_byte(input logic f, input logic [7:0] b);
    frame_res_t  r;
    logic [10:0] nxt;
    r = '{data: 8'h00, kind: KIND_NONE, blk: 8'h00};
    live_items++;
    if (f) begin
      rx_phase  = PH_BOUNDARY;
      want_seq  = SEQ_FIRST;
      pay_count = '0;
    end else begin
      case (rx_phase)
        PH_BOUNDARY: begin
          if (b == BYTE_EOT) begin
            r.kind   = KIND_END_ACK;
            rx_phase = PH_STOPPED;
          end else if (b == BYTE_SOH) begin
            rx_phase = PH_SEQ;
          end else begin
            r.kind   = KIND_ERROR;
            rx_phase = PH_STOPPED;
          end
        end
        PH_SEQ: begin
          if (b == want_seq) begin
            rx_phase = PH_CSEQ;
          end else begin
            r.kind   = KIND_ERROR;
            rx_phase = PH_STOPPED;
          end
        end
        PH_CSEQ: begin
          if ({1'b0, b} + {1'b0, want_seq} == CSEQ_SUM) begin
            rx_phase  = PH_PAYLOAD;
            pay_count = '0;
          end else begin
            r.kind   = KIND_ERROR;
            rx_phase = PH_STOPPED;
          end
        end
        PH_PAYLOAD: begin
          r.kind = KIND_PAYLOAD;
          r.data = b;
          nxt    = {1'b0, pay_count} + 11'd1;
          if (nxt >= BLOCK_LAST) begin
            pay_count = '0;
            if (TRAILER_BYTES == 0) begin
              r.kind   = KIND_BLOCK_ACK;
              want_seq = want_seq + 8'd1;
              rx_phase = PH_BOUNDARY;
            end else begin
              rx_phase = PH_TRAILER;
            end
          end else begin
            pay_count = nxt[9:0];
          end
        end
        PH_TRAILER: begin
          nxt = {1'b0, pay_count} + 11'd1;
          if (nxt >= TRAILER_LAST) begin
            r.kind    = KIND_BLOCK_ACK;
            want_seq  = want_seq + 8'd1;
            pay_count = '0;
            rx_phase  = PH_BOUNDARY;
          end else begin
            pay_count = nxt[9:0];
          end
        end
        default: ;
      endcase
    end
    r.blk = want_seq;
    pending_results.push_back(r);
  endfunction

  // hold the transfer until accepted, then maybe idle for a burst
  task automatic send_item(input logic f, input logic [7:0] b);
    in_func    <= f;
    in_rx_byte <= b;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    deframe_byte(f, b);
    if (idle_en && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // header, payload and trailer for the current block number, with an optional fault
  task automatic send_block(input int fault);
    logic [7:0] s;
    int         cut;
    s = want_seq;
    send_item(1'b0, BYTE_SOH);
    if (fault == FAULT_SEQ) begin
      send_item(1'b0, s ^ 8'($urandom_range(1, 255)));
      return;
    end
    send_item(1'b0, s);
    if (fault == FAULT_CSEQ) begin
      send_item(1'b0, ~s ^ 8'($urandom_range(1, 255)));
      return;
    end
    send_item(1'b0, ~s);
    cut = (fault == FAULT_RESTART) ? $urandom_range(0, BLOCK_BYTES - 1)
                                   : BLOCK_BYTES + TRAILER_BYTES;
    for (int i = 0; i < BLOCK_BYTES + TRAILER_BYTES; i++) begin
      if (i == cut) begin
        send_item(1'b1, rnd_byte());
        return;
      end
      send_item(1'b0, rnd_byte());
    end
  endtask

  task automatic test_directed();
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h00);
    send_item(1'b0, BYTE_SOH);
    send_item(1'b1, 8'hA5);
    send_item(1'b0, 8'h00);
    send_item(1'b0, BYTE_EOT);
    send_item(1'b1, 8'h00);
    send_item(1'b0, BYTE_EOT);
    send_item(1'b0, BYTE_SOH);
    send_item(1'b1, 8'hFF);
    send_item(1'b0, BYTE_SOH);
    send_item(1'b0, 8'h02);
    send_item(1'b1, 8'h3C);
    send_item(1'b0, BYTE_SOH);
    send_item(1'b0, 8'h01);
    send_item(1'b0, 8'h00);
    send_item(1'b1, 8'h81);
    send_item(1'b0, BYTE_SOH);
    send_item(1'b1, 8'h7E);
    send_item(1'b0, BYTE_SOH);
    send_item(1'b0, 8'h01);
    send_item(1'b0, 8'hFE);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h00);
    send_item(1'b1, 8'h5A);
    send_item(1'b0, 8'hFF);
  endtask

  task automatic test_random_sessions();
    int base;
    int fault;
    int n;
    logic [7:0] b;
    base = live_items;
    while (live_items - base < RANDOM_ITEMS) begin
      idle_en = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 6) begin
        send_item(1'b1, rnd_byte());
        fault = FAULT_NONE;
        n = $urandom_range(1, 3);
        for (int k = 0; k < n && fault == FAULT_NONE && live_items - base < RANDOM_ITEMS;
             k++) begin
          case ($urandom_range(0, 5))
            0: fault = FAULT_SEQ;
            1: fault = FAULT_CSEQ;
            2: fault = FAULT_RESTART;
            default: fault = FAULT_NONE;
          endcase
          send_block(fault);
        end
        if (fault == FAULT_NONE) begin
          case ($urandom_range(0, 2))
            0: send_item(1'b0, BYTE_EOT);
            1: begin
              do b = rnd_byte(); while (b == BYTE_SOH || b == BYTE_EOT);
              send_item(1'b0, b);
            end
            default: ;
          endcase
        end
      end else begin
        // noise, biased toward framing bytes so it gets past the boundary now and then
        n = $urandom_range(1, 24);
        for (int k = 0; k < n; k++) begin
          case ($urandom_range(0, 7))
            0: b = BYTE_SOH;
            1: b = BYTE_EOT;
            2: b = want_seq;
            3: b = ~want_seq;
            default: b = rnd_byte();
          endcase
          send_item($urandom_range(0, 15) == 0, b);
        end
      end
    end
  endtask

  // full block and end with no idling on either side
  task automatic test_back_to_back();
    idle_en = 1'b0;
    send_item(1'b1, rnd_byte());
    send_block(FAULT_NONE);
    send_item(1'b0, BYTE_EOT);
  endtask

  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_r = '{data: out_byte, kind: out_kind, blk: out_block_number};
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, actual kind %0d byte %0d",
                 $time, got_r.kind, got_r.data);
      end else begin
        want_r = pending_results.pop_front();
        check_field("out_byte", want_r.data, got_r.data);
        check_field("out_kind", {5'b0, want_r.kind}, {5'b0, got_r.kind});
        check_field("out_block_number", want_r.blk, got_r.blk);
      end
    end
  end

  // receiver stalls in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (rst_n && idle_en && $urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(1, 18) - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_run <= 0;
    end else if (idle_run >= WATCHDOG_LIMIT) begin
      $display("tb_block_transfer_deframer NOT OK");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_sessions();
    test_back_to_back();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("tb_block_transfer_deframer OK");
    end else begin
      $display("tb_block_transfer_deframer NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/btd_pkg.sv
rtl/btd_step.sv
rtl/block_transfer_deframer.sv
test/tb_block_transfer_deframer.sv
